// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers shared by the RTL modules.
// No dependencies; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/dlr_pkg.sv =====
// dlr_pkg: shared constants, codes and types of the DDA line rasterizer.
// No dependencies; used by every other RTL file except assert_macros.svh.
package dlr_pkg;

    localparam int DLR_COORD_BITS = 16;
    localparam int DLR_FRAC_BITS  = 16;

    localparam int DIM_W      = 13;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(512);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(512);
    localparam logic [COLOR_W-1:0] COLOR_RST  = '0;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_DRAW_COLOR   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_ROUND,
        ST_MULT,
        ST_ADDR,
        ST_OUT
    } t_dlr_state;

    typedef struct packed {
        logic in_valid;
        logic mode;
        logic steps_zero;
        logic line_active;
        logic div_busy;
        logic div_done;
        logic out_ready;
    } t_dlr_stat;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic advance;
        logic idle_step;
        logic div_start;
        logic div_sel_y;
        logic round_en;
        logic mult_en;
        logic addr_en;
        logic out_valid;
    } t_dlr_ctrl;

endpackage

// ===== hw/rtl/dlr_in_if.sv =====
// dlr_in_if: input channel of the line rasterizer, valid/ready plus one line command.
// Depends on dlr_pkg for the default coordinate width.
interface dlr_in_if #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== hw/rtl/dlr_out_if.sv =====
// dlr_out_if: pixel channel of the line rasterizer, valid/ready plus one pixel record.
// Depends on dlr_pkg for widths.
interface dlr_out_if #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS
);
    logic                              valid;
    logic                              ready;
    logic                              valid_pixel;
    logic signed [COORD_BITS-1:0]      pixel_x;
    logic signed [COORD_BITS-1:0]      pixel_y;
    logic                              in_image;
    logic [dlr_pkg::ADDR_W-1:0]        pixel_address;
    logic [dlr_pkg::COLOR_W-1:0]       pixel_color;
    logic                              last_pixel;

    modport source (output valid, valid_pixel, pixel_x, pixel_y, in_image, pixel_address,
                    pixel_color, last_pixel, input ready);
    modport sink (input valid, valid_pixel, pixel_x, pixel_y, in_image, pixel_address,
                  pixel_color, last_pixel, output ready);
endinterface

// ===== hw/rtl/dlr_divider.sv =====
// dlr_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on dlr_pkg and assert_macros.svh; shared by both axis increments of a line load.
`include "assert_macros.svh"

module dlr_divider #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS,
    parameter int FRAC_BITS  = dlr_pkg::DLR_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [COORD_BITS+FRAC_BITS-1:0] i_dividend,
    input  logic [COORD_BITS-1:0]           i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_quot
);
    localparam int DW    = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DW-1:0]         r_quo;
    logic [DW-1:0]         n_quo;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] n_rem;
    logic [COORD_BITS:0]   rem_sh;
    logic [COORD_BITS:0]   rem_sub;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh  = {r_rem, r_quo[DW-1]};
        rem_sub = rem_sh - {1'b0, i_divisor};
        n_quo   = {r_quo[DW-2:0], 1'b0};
        n_rem   = rem_sh[COORD_BITS-1:0];
        if (!rem_sub[COORD_BITS]) begin
            n_rem    = rem_sub[COORD_BITS-1:0];
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == LAST);
    assign o_quot = n_quo;

    `ASSERT_IMPL(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)

endmodule

// ===== hw/rtl/dlr_seq.sv =====
// dlr_seq: sequencer of the line rasterizer (load, two divisions, pixel stages, hand-off).
// Depends on dlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlr_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlr_pkg::t_dlr_stat i_stat,
    output dlr_pkg::t_dlr_ctrl o_ctrl
);
    dlr_pkg::t_dlr_state r_state;
    dlr_pkg::t_dlr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dlr_pkg::ST_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.mode == dlr_pkg::MODE_LOAD && !i_stat.steps_zero) begin
                        n_state = dlr_pkg::ST_DIV_X;
                    end else begin
                        n_state = dlr_pkg::ST_ROUND;
                    end
                end
            end
            dlr_pkg::ST_DIV_X: begin
                if (i_stat.div_done) begin
                    n_state = dlr_pkg::ST_DIV_Y;
                end
            end
            dlr_pkg::ST_DIV_Y: begin
                if (i_stat.div_done) begin
                    n_state = dlr_pkg::ST_ROUND;
                end
            end
            dlr_pkg::ST_ROUND: n_state = dlr_pkg::ST_MULT;
            dlr_pkg::ST_MULT:  n_state = dlr_pkg::ST_ADDR;
            dlr_pkg::ST_ADDR:  n_state = dlr_pkg::ST_OUT;
            dlr_pkg::ST_OUT: begin
                if (i_stat.out_ready) begin
                    n_state = dlr_pkg::ST_IDLE;
                end
            end
            default: n_state = dlr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            dlr_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    if (i_stat.mode == dlr_pkg::MODE_LOAD) begin
                        o_ctrl.load = 1'b1;
                    end else if (i_stat.line_active) begin
                        o_ctrl.advance = 1'b1;
                    end else begin
                        o_ctrl.idle_step = 1'b1;
                    end
                end
            end
            dlr_pkg::ST_DIV_X: begin
                o_ctrl.div_start = !i_stat.div_busy;
            end
            dlr_pkg::ST_DIV_Y: begin
                o_ctrl.div_start = !i_stat.div_busy;
                o_ctrl.div_sel_y = 1'b1;
            end
            dlr_pkg::ST_ROUND: o_ctrl.round_en  = 1'b1;
            dlr_pkg::ST_MULT:  o_ctrl.mult_en   = 1'b1;
            dlr_pkg::ST_ADDR:  o_ctrl.addr_en   = 1'b1;
            dlr_pkg::ST_OUT:   o_ctrl.out_valid = 1'b1;
            default: ;
        endcase
    end

    `ASSERT_NEXT(a_load_divides, i_clk, i_rst_n, r_state == dlr_pkg::ST_IDLE && i_stat.in_valid && i_stat.mode == dlr_pkg::MODE_LOAD && !i_stat.steps_zero, r_state == dlr_pkg::ST_DIV_X)

endmodule

// ===== hw/rtl/dlr_pixel.sv =====
// dlr_pixel: rounding, bounds check and byte address of one pixel over three stages.
// Depends on dlr_pkg; driven by the dlr_seq enables.
module dlr_pixel #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS,
    parameter int FRAC_BITS  = dlr_pkg::DLR_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  dlr_pkg::t_dlr_ctrl                    i_ctrl,
    input  logic [COORD_BITS+FRAC_BITS+1:0]       i_acc_x,
    input  logic [COORD_BITS+FRAC_BITS+1:0]       i_acc_y,
    input  logic [dlr_pkg::DIM_W-1:0]             i_width,
    input  logic [dlr_pkg::DIM_W-1:0]             i_height,
    input  logic [dlr_pkg::COLOR_W-1:0]           i_color,
    input  logic                                  i_valid_px,
    input  logic                                  i_last,
    output logic                                  o_valid_pixel,
    output logic [COORD_BITS-1:0]                 o_pixel_x,
    output logic [COORD_BITS-1:0]                 o_pixel_y,
    output logic                                  o_in_image,
    output logic [dlr_pkg::ADDR_W-1:0]            o_pixel_address,
    output logic [dlr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic                                  o_last_pixel
);
    localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
    localparam int PX_W  = COORD_BITS + 2;
    localparam int DIM_W = dlr_pkg::DIM_W;
    localparam int ADDR_W = dlr_pkg::ADDR_W;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [ACC_W-1:0]        biased_x;
    logic [ACC_W-1:0]        biased_y;
    logic [PX_W-1:0]         rnd_x;
    logic [PX_W-1:0]         rnd_y;
    logic [PX_W-1:0]         r_px;
    logic [PX_W-1:0]         r_py;
    logic [PX_W+DIM_W-1:0]   px_wide;
    logic [PX_W+DIM_W-1:0]   py_wide;
    logic                    in_bounds;
    logic                    r_inside;
    logic [ADDR_W-1:0]       r_prod;
    logic [ADDR_W-1:0]       sum;
    logic [ADDR_W-1:0]       addr;

    logic                    r_valid_pixel;
    logic [COORD_BITS-1:0]   r_pixel_x;
    logic [COORD_BITS-1:0]   r_pixel_y;
    logic                    r_in_image;
    logic [ADDR_W-1:0]       r_pixel_address;
    logic [dlr_pkg::COLOR_W-1:0] r_pixel_color;
    logic                    r_last_pixel;

    // floor of (acc + half) >> FRAC_BITS, then bump negatives with a remainder toward zero
    always_comb begin
        biased_x = i_acc_x + HALF;
        biased_y = i_acc_y + HALF;
        rnd_x = biased_x[ACC_W-1:FRAC_BITS]
              + PX_W'(biased_x[ACC_W-1] && (biased_x[FRAC_BITS-1:0] != '0));
        rnd_y = biased_y[ACC_W-1:FRAC_BITS]
              + PX_W'(biased_y[ACC_W-1] && (biased_y[FRAC_BITS-1:0] != '0));
    end

    always_comb begin
        px_wide = {{DIM_W{1'b0}}, r_px};
        py_wide = {{DIM_W{1'b0}}, r_py};
        in_bounds = !r_px[PX_W-1] && !r_py[PX_W-1]
                 && (px_wide < {{PX_W{1'b0}}, i_width})
                 && (py_wide < {{PX_W{1'b0}}, i_height});
        sum     = r_prod + {{(ADDR_W-DIM_W){1'b0}}, px_wide[DIM_W-1:0]};
        addr    = sum + {sum[ADDR_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.round_en) begin
            r_px <= rnd_x;
            r_py <= rnd_y;
        end
        if (i_ctrl.mult_en) begin
            r_inside <= in_bounds;
            r_prod   <= ADDR_W'(py_wide[DIM_W-1:0]) * ADDR_W'(i_width);
        end
        if (i_ctrl.addr_en) begin
            r_valid_pixel   <= i_valid_px;
            r_pixel_x       <= i_valid_px ? r_px[COORD_BITS-1:0] : '0;
            r_pixel_y       <= i_valid_px ? r_py[COORD_BITS-1:0] : '0;
            r_in_image      <= i_valid_px && r_inside;
            r_pixel_address <= (i_valid_px && r_inside) ? addr : '0;
            r_pixel_color   <= i_valid_px ? i_color : '0;
            r_last_pixel    <= i_valid_px && i_last;
        end
    end

    assign o_valid_pixel   = r_valid_pixel;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_in_image      = r_in_image;
    assign o_pixel_address = r_pixel_address;
    assign o_pixel_color   = r_pixel_color;
    assign o_last_pixel    = r_last_pixel;

endmodule

// ===== hw/rtl/dda_line_rasterizer_unit.sv =====
// dda_line_rasterizer_unit: top level of the DDA line rasterizer.
// Depends on dlr_pkg, dlr_in_if, dlr_out_if, dlr_divider, dlr_seq, dlr_pixel, assert_macros.svh.
//
//  port          dir   kind          carries
//  i_in          in    valid/ready   mode, start_x, start_y, end_x, end_y
//  o_out         out   valid/ready   valid_pixel, pixel_x/y, in_image, address, color, last
//  i_cfg_*       in    write only    frame width, frame height, pixel color
//
// One transaction at a time: i_in.ready is high only while the block is idle.
// A step passes the round, multiply and address states to a valid pixel; after hand-off the block
// returns to idle and takes the next one. A load of a line with a nonzero step count first adds
// two divisions on the shared divider, one for each axis increment.
// A pixel held on o_out stalls the block until o_out.ready; reset is synchronous, active low.
`include "assert_macros.svh"

module dda_line_rasterizer_unit #(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS,
    parameter int FRAC_BITS  = dlr_pkg::DLR_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dlr_in_if.sink                            i_in,
    dlr_out_if.source                         o_out
);
    localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int DW    = COORD_BITS + FRAC_BITS;
    localparam int DIM_W = dlr_pkg::DIM_W;

    logic [DIM_W-1:0]            r_width;
    logic [DIM_W-1:0]            r_height;
    logic [dlr_pkg::COLOR_W-1:0] r_color;

    logic [ACC_W-1:0]      r_acc_x;
    logic [ACC_W-1:0]      r_acc_y;
    logic [INC_W-1:0]      r_inc_x;
    logic [INC_W-1:0]      r_inc_y;
    logic [COORD_BITS-1:0] r_steps_left;
    logic                  r_line_active;
    logic                  r_last;
    logic                  r_valid_px;
    logic [COORD_BITS-1:0] r_abs_dx;
    logic [COORD_BITS-1:0] r_abs_dy;
    logic                  r_neg_x;
    logic                  r_neg_y;
    logic [COORD_BITS-1:0] r_steps;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   mag_x;
    logic [COORD_BITS:0]   mag_y;
    logic [COORD_BITS-1:0] steps;
    logic                  steps_zero;
    logic [ACC_W-1:0]      start_acc_x;
    logic [ACC_W-1:0]      start_acc_y;

    logic [DW-1:0]         div_dividend;
    logic                  div_busy;
    logic                  div_done;
    logic [DW-1:0]         div_quot;
    logic [INC_W-1:0]      quot_inc;
    logic [INC_W-1:0]      new_inc;

    dlr_pkg::t_dlr_stat    stat;
    dlr_pkg::t_dlr_ctrl    ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dlr_pkg::WIDTH_RST;
            r_height <= dlr_pkg::HEIGHT_RST;
            r_color  <= dlr_pkg::COLOR_RST;
        end else if (i_cfg_we) begin
            case (dlr_pkg::t_cfg_index'(i_cfg_index))
                dlr_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                dlr_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                dlr_pkg::CFG_DRAW_COLOR:   r_color  <= i_cfg_data[dlr_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // deltas, magnitudes and the step count of a new line
    always_comb begin
        dx    = {i_in.end_x[COORD_BITS-1], i_in.end_x}
              - {i_in.start_x[COORD_BITS-1], i_in.start_x};
        dy    = {i_in.end_y[COORD_BITS-1], i_in.end_y}
              - {i_in.start_y[COORD_BITS-1], i_in.start_y};
        mag_x = dx[COORD_BITS] ? -dx : dx;
        mag_y = dy[COORD_BITS] ? -dy : dy;
        steps = (mag_x[COORD_BITS-1:0] > mag_y[COORD_BITS-1:0])
              ? mag_x[COORD_BITS-1:0] : mag_y[COORD_BITS-1:0];
        steps_zero  = (steps == '0);
        start_acc_x = {{2{i_in.start_x[COORD_BITS-1]}}, i_in.start_x, {FRAC_BITS{1'b0}}};
        start_acc_y = {{2{i_in.start_y[COORD_BITS-1]}}, i_in.start_y, {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        div_dividend = {ctrl.div_sel_y ? r_abs_dy : r_abs_dx, {FRAC_BITS{1'b0}}};
        quot_inc     = div_quot[INC_W-1:0];
        new_inc      = (ctrl.div_sel_y ? r_neg_y : r_neg_x) ? -quot_inc : quot_inc;
    end

    dlr_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        stat.in_valid    = i_in.valid;
        stat.mode        = i_in.mode;
        stat.steps_zero  = steps_zero;
        stat.line_active = r_line_active;
        stat.div_busy    = div_busy;
        stat.div_done    = div_done;
        stat.out_ready   = o_out.ready;
    end

    dlr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // line control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_steps_left  <= '0;
            r_last        <= 1'b0;
            r_valid_px    <= 1'b0;
        end else if (ctrl.load) begin
            r_line_active <= !steps_zero;
            r_steps_left  <= steps;
            r_last        <= steps_zero;
            r_valid_px    <= 1'b1;
        end else if (ctrl.advance) begin
            r_line_active <= (r_steps_left != COORD_BITS'(1));
            r_steps_left  <= r_steps_left - COORD_BITS'(1);
            r_last        <= (r_steps_left == COORD_BITS'(1));
            r_valid_px    <= 1'b1;
        end else if (ctrl.idle_step) begin
            r_last     <= 1'b0;
            r_valid_px <= 1'b0;
        end
    end

    // position accumulators and increments
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_acc_x  <= start_acc_x;
            r_acc_y  <= start_acc_y;
            r_abs_dx <= mag_x[COORD_BITS-1:0];
            r_abs_dy <= mag_y[COORD_BITS-1:0];
            r_neg_x  <= dx[COORD_BITS];
            r_neg_y  <= dy[COORD_BITS];
            r_steps  <= steps;
            r_inc_x  <= '0;
            r_inc_y  <= '0;
        end else if (ctrl.advance) begin
            r_acc_x <= r_acc_x + {{(ACC_W-INC_W){r_inc_x[INC_W-1]}}, r_inc_x};
            r_acc_y <= r_acc_y + {{(ACC_W-INC_W){r_inc_y[INC_W-1]}}, r_inc_y};
        end
        if (div_done && !ctrl.div_sel_y) begin
            r_inc_x <= new_inc;
        end
        if (div_done && ctrl.div_sel_y) begin
            r_inc_y <= new_inc;
        end
    end

    dlr_pixel #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_pixel (
        .i_clk           (i_clk),
        .i_ctrl          (ctrl),
        .i_acc_x         (r_acc_x),
        .i_acc_y         (r_acc_y),
        .i_width         (r_width),
        .i_height        (r_height),
        .i_color         (r_color),
        .i_valid_px      (r_valid_px),
        .i_last          (r_last),
        .o_valid_pixel   (o_out.valid_pixel),
        .o_pixel_x       (o_out.pixel_x),
        .o_pixel_y       (o_out.pixel_y),
        .o_in_image      (o_out.in_image),
        .o_pixel_address (o_out.pixel_address),
        .o_pixel_color   (o_out.pixel_color),
        .o_last_pixel    (o_out.last_pixel)
    );

    assign i_in.ready  = ctrl.in_ready;
    assign o_out.valid = ctrl.out_valid;

    `ASSERT_IMPL(a_active_has_steps, i_clk, i_rst_n, r_line_active, r_steps_left != '0)
    `ASSERT_IMPL(a_no_accept_on_hold, i_clk, i_rst_n, ctrl.out_valid, !ctrl.in_ready && !div_busy)

endmodule
